// ===== design/ytgs_pkg.sv =====
// ----------------------------------------------------------------------------
// ytgs_pkg
// Shared types and constants for the YUV threshold ground segmenter.
// ----------------------------------------------------------------------------
package ytgs_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   localparam int BYTE_WIDTH  = 8;
   localparam int DIM_WIDTH   = 11;
   localparam int POS_WIDTH   = 10;
   localparam int COUNT_WIDTH = 21;
   localparam int TOTAL_WIDTH = 21;
   localparam int PCT_WIDTH   = 15;
   localparam int PROD_WIDTH  = COUNT_WIDTH + PCT_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_WIDTH-1:0] PAINT_U = 8'd84;
   localparam logic [BYTE_WIDTH-1:0] PAINT_Y = 8'd76;
   localparam logic [BYTE_WIDTH-1:0] PAINT_V = 8'd255;
   localparam logic [PCT_WIDTH-1:0]  PCT_FULL = 15'd25600;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LUMA_MIN     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BLUE_MAX     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RED_MAX      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRAW_ENABLE  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FRAME_HEIGHT = 3'd5;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  chroma_blue;
      logic [BYTE_WIDTH-1:0]  luma_first;
      logic [BYTE_WIDTH-1:0]  chroma_red;
      logic [BYTE_WIDTH-1:0]  luma_second;
   } word_type;

   // One classified request handed from front to back.
   typedef struct packed {
      word_type               word;
      logic                   ground;
      logic                   frame_done;
      logic [COUNT_WIDTH-1:0] count;
      logic [DIM_WIDTH-1:0]   width;
      logic [DIM_WIDTH-1:0]   height;
   } entry_type;

   typedef struct packed {
      word_type               word;
      logic                   ground;
      logic                   frame_done;
      logic [PCT_WIDTH-1:0]   pct;
   } result_type;

endpackage

// ===== design/ytgs_queue.sv =====
// ----------------------------------------------------------------------------
// ytgs_queue
// Small register queue between the classifier front and the result back.
// ----------------------------------------------------------------------------
module ytgs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ytgs_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output ytgs_pkg::entry_type  head
);

   ytgs_pkg::entry_type                       mem_ff [ytgs_pkg::QUEUE_DEPTH];
   logic [ytgs_pkg::QUEUE_PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ytgs_pkg::QUEUE_PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ytgs_pkg::QUEUE_CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic                                      do_push, do_pop;

   assign full    = (cnt_ff == ytgs_pkg::QUEUE_CNT_WIDTH'(ytgs_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + ytgs_pkg::QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + ytgs_pkg::QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + ytgs_pkg::QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - ytgs_pkg::QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/ytgs_front.sv =====
// ----------------------------------------------------------------------------
// ytgs_front
// Register file, pixel-pair classification, frame position and ground count.
// ----------------------------------------------------------------------------
module ytgs_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ytgs_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [ytgs_pkg::DIM_WIDTH-1:0]          csr_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  ytgs_pkg::word_type                      req_word,
   input  logic                                    queue_full,
   output logic                                    queue_push,
   output ytgs_pkg::entry_type                     queue_data
);

   logic [ytgs_pkg::BYTE_WIDTH-1:0]  luma_min_ff, blue_max_ff, red_max_ff;
   logic                             draw_enable_ff;
   logic [ytgs_pkg::DIM_WIDTH-1:0]   frame_width_ff, frame_height_ff;

   logic [ytgs_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [ytgs_pkg::POS_WIDTH-1:0]   col_ff, col_in;
   logic [ytgs_pkg::POS_WIDTH-1:0]   row_ff, row_in;

   logic [ytgs_pkg::DIM_WIDTH-1:0]   used_w, used_h, even_w;
   logic                             ground, row_end, frame_end, accept;
   logic [ytgs_pkg::COUNT_WIDTH-1:0] count_sum;
   ytgs_pkg::word_type               word_out;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_min_ff     <= 8'd100;
         blue_max_ff     <= 8'd128;
         red_max_ff      <= 8'd128;
         draw_enable_ff  <= 1'b1;
         frame_width_ff  <= 11'd320;
         frame_height_ff <= 11'd240;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ytgs_pkg::CSR_LUMA_MIN:     luma_min_ff     <= csr_data[7:0];
            ytgs_pkg::CSR_BLUE_MAX:     blue_max_ff     <= csr_data[7:0];
            ytgs_pkg::CSR_RED_MAX:      red_max_ff      <= csr_data[7:0];
            ytgs_pkg::CSR_DRAW_ENABLE:  draw_enable_ff  <= csr_data[0];
            ytgs_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            ytgs_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      even_w = {frame_width_ff[ytgs_pkg::DIM_WIDTH-1:1], 1'b0};
      if (even_w < 11'd2) begin
         used_w = 11'd2;
      end else if (even_w > ytgs_pkg::DIM_WIDTH'(ytgs_pkg::MAX_WIDTH)) begin
         used_w = ytgs_pkg::DIM_WIDTH'(ytgs_pkg::MAX_WIDTH);
      end else begin
         used_w = even_w;
      end
      if (frame_height_ff == '0) begin
         used_h = 11'd1;
      end else if (frame_height_ff > ytgs_pkg::DIM_WIDTH'(ytgs_pkg::MAX_HEIGHT)) begin
         used_h = ytgs_pkg::DIM_WIDTH'(ytgs_pkg::MAX_HEIGHT);
      end else begin
         used_h = frame_height_ff;
      end
   end

   always_comb begin
      ground = (req_word.luma_first  > luma_min_ff) &&
               (req_word.luma_second > luma_min_ff) &&
               (req_word.chroma_blue < blue_max_ff) &&
               (req_word.chroma_red  < red_max_ff);
      count_sum = ground ? count_ff + ytgs_pkg::COUNT_WIDTH'(2) : count_ff;

      word_out = req_word;
      if (!ground && draw_enable_ff) begin
         word_out.chroma_blue = ytgs_pkg::PAINT_U;
         word_out.luma_first  = ytgs_pkg::PAINT_Y;
         word_out.chroma_red  = ytgs_pkg::PAINT_V;
         word_out.luma_second = ytgs_pkg::PAINT_Y;
      end

      row_end   = ({1'b0, col_ff} + 11'd2) >= used_w;
      frame_end = row_end && (({1'b0, row_ff} + 11'd1) >= used_h);

      count_in = count_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         priority if (frame_end) begin
            count_in = '0;
            col_in   = '0;
            row_in   = '0;
         end else if (row_end) begin
            count_in = count_sum;
            col_in   = '0;
            row_in   = row_ff + ytgs_pkg::POS_WIDTH'(1);
         end else begin
            count_in = count_sum;
            col_in   = col_ff + ytgs_pkg::POS_WIDTH'(2);
         end
      end

      queue_data.word       = word_out;
      queue_data.ground     = ground;
      queue_data.frame_done = frame_end;
      queue_data.count      = count_sum;
      queue_data.width      = used_w;
      queue_data.height     = used_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         count_ff <= count_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

// ===== design/ytgs_back.sv =====
// ----------------------------------------------------------------------------
// ytgs_back
// Result stage: passes pixel words out, runs the end-of-frame share divider.
// ----------------------------------------------------------------------------
module ytgs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  ytgs_pkg::entry_type  queue_head,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ytgs_pkg::result_type rsp_result
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam int STEP_WIDTH = $clog2(ytgs_pkg::PCT_WIDTH);

   logic [2:0]                           state_ff, state_in;
   logic [STEP_WIDTH-1:0]                step_ff, step_in;
   ytgs_pkg::entry_type                  work_ff, work_in;
   logic [ytgs_pkg::PROD_WIDTH-1:0]      prod_ff, prod_in;
   logic [ytgs_pkg::TOTAL_WIDTH-1:0]     total_ff, total_in;
   logic [ytgs_pkg::TOTAL_WIDTH-1:0]     rem_ff, rem_in;
   logic [ytgs_pkg::PCT_WIDTH-1:0]       quo_ff, quo_in;
   ytgs_pkg::result_type                 out_ff, out_in;
   logic                                 valid_ff, valid_in;

   logic                                 out_free, take;
   logic [ytgs_pkg::TOTAL_WIDTH:0]       shifted, diff;
   logic [2*ytgs_pkg::DIM_WIDTH-1:0]     area;

   assign out_free   = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      work_in   = work_ff;
      prod_in   = prod_ff;
      total_in  = total_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      out_in    = out_ff;
      valid_in  = valid_ff && rsp_stall;
      queue_pop = 1'b0;
      take      = 1'b0;
      area      = {{ytgs_pkg::DIM_WIDTH{1'b0}}, work_ff.width} *
                  {{ytgs_pkg::DIM_WIDTH{1'b0}}, work_ff.height};
      shifted   = {rem_ff, quo_ff[ytgs_pkg::PCT_WIDTH-1]};
      diff      = shifted - {1'b0, total_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               if (queue_head.frame_done) begin
                  queue_pop = 1'b1;
                  work_in   = queue_head;
                  state_in  = S_MUL;
               end else if (out_free) begin
                  queue_pop     = 1'b1;
                  take          = 1'b1;
                  out_in.word   = queue_head.word;
                  out_in.ground = queue_head.ground;
                  out_in.frame_done = 1'b0;
                  out_in.pct    = '0;
               end
            end
         end
         S_MUL: begin
            prod_in  = ytgs_pkg::PROD_WIDTH'(work_ff.count) *
                       ytgs_pkg::PROD_WIDTH'(ytgs_pkg::PCT_FULL);
            total_in = area[ytgs_pkg::TOTAL_WIDTH-1:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (work_ff.count >= total_ff) begin
               quo_in   = ytgs_pkg::PCT_FULL;
               state_in = S_OUT;
            end else begin
               rem_in   = prod_ff[ytgs_pkg::PROD_WIDTH-1:ytgs_pkg::PCT_WIDTH];
               quo_in   = prod_ff[ytgs_pkg::PCT_WIDTH-1:0];
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!diff[ytgs_pkg::TOTAL_WIDTH]) begin
               rem_in = diff[ytgs_pkg::TOTAL_WIDTH-1:0];
            end else begin
               rem_in = shifted[ytgs_pkg::TOTAL_WIDTH-1:0];
            end
            quo_in  = {quo_ff[ytgs_pkg::PCT_WIDTH-2:0], !diff[ytgs_pkg::TOTAL_WIDTH]};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(ytgs_pkg::PCT_WIDTH - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               take              = 1'b1;
               out_in.word       = work_ff.word;
               out_in.ground     = work_ff.ground;
               out_in.frame_done = 1'b1;
               out_in.pct        = quo_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      work_ff  <= work_in;
      prod_ff  <= prod_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      out_ff   <= out_in;
   end

`ifndef NO_ASSERTIONS
   a_pct_only_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ff.frame_done |-> out_ff.pct == '0)
      else $error("share reported on a word that does not end a frame");

   a_pct_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> out_ff.pct <= ytgs_pkg::PCT_FULL)
      else $error("share above full scale");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < total_ff)
      else $error("divider remainder not below frame area");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !queue_pop)
      else $error("queue popped while frame share in progress");
`endif

endmodule

// ===== design/yuv_threshold_ground_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// yuv_threshold_ground_segmenter_unit
// Classifies UYVY pixel pairs as ground and reports the ground share per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one UYVY word (U, Y0, V, Y1) per request, taken when req_valid is
//            high and req_stall is low.
//   rsp_*  : one result per request, in order, taken when rsp_valid is high
//            and rsp_stall is low. The result register holds while stalled.
//   csr_*  : register writes (index 0..5), always ready; write only when idle.
// Path: a plain word passes through the queue and the result register to rsp.
// Throughput: one word per cycle unless stalled. The word closing a frame runs
//   a 15-step restoring divider for the ground share (skipped when the whole
//   frame is ground) in the back stage; a 4-entry queue keeps taking requests
//   meanwhile, then req_stall rises until the divider is done.
// Reset: registers return to their defaults, frame position, ground count,
//   queue and output valid flag clear.
// A stall on rsp backs up the queue and then raises req_stall.
// ----------------------------------------------------------------------------
module yuv_threshold_ground_segmenter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ytgs_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [ytgs_pkg::DIM_WIDTH-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ytgs_pkg::BYTE_WIDTH-1:0]     req_chroma_blue,
   input  logic [ytgs_pkg::BYTE_WIDTH-1:0]     req_luma_first,
   input  logic [ytgs_pkg::BYTE_WIDTH-1:0]     req_chroma_red,
   input  logic [ytgs_pkg::BYTE_WIDTH-1:0]     req_luma_second,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ytgs_pkg::BYTE_WIDTH-1:0]     rsp_out_chroma_blue,
   output logic [ytgs_pkg::BYTE_WIDTH-1:0]     rsp_out_luma_first,
   output logic [ytgs_pkg::BYTE_WIDTH-1:0]     rsp_out_chroma_red,
   output logic [ytgs_pkg::BYTE_WIDTH-1:0]     rsp_out_luma_second,
   output logic                                rsp_pair_is_ground,
   output logic                                rsp_frame_done,
   output logic [ytgs_pkg::PCT_WIDTH-1:0]      rsp_ground_percent
);

   ytgs_pkg::word_type    req_word;
   ytgs_pkg::entry_type   push_data, head;
   ytgs_pkg::result_type  result;
   logic                  push, pop, full, empty;

   assign req_word.chroma_blue = req_chroma_blue;
   assign req_word.luma_first  = req_luma_first;
   assign req_word.chroma_red  = req_chroma_red;
   assign req_word.luma_second = req_luma_second;

   ytgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (full),
      .queue_push (push),
      .queue_data (push_data)
   );

   ytgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   ytgs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .queue_head  (head),
      .queue_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (result)
   );

   assign rsp_out_chroma_blue = result.word.chroma_blue;
   assign rsp_out_luma_first  = result.word.luma_first;
   assign rsp_out_chroma_red  = result.word.chroma_red;
   assign rsp_out_luma_second = result.word.luma_second;
   assign rsp_pair_is_ground  = result.ground;
   assign rsp_frame_done      = result.frame_done;
   assign rsp_ground_percent  = result.pct;

endmodule
